FILE: sv/output_script_template_classifier_assert.svh
// Assertion macros shared by the classifier's checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef OUTPUT_SCRIPT_TEMPLATE_CLASSIFIER_ASSERT_SVH
`define OUTPUT_SCRIPT_TEMPLATE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define OSTC_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OSTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ostc_pkg.sv
// Constants, template tables and the per-byte template compare for the classifier.
// No dependencies.
package ostc_pkg;

    // Config register indexes
    localparam logic CFG_CHAIN_VARIANT  = 1'b0;
    localparam logic CFG_WITNESS_ENABLE = 1'b1;

    // chain_variant codes (3 behaves as plain)
    localparam logic [1:0] VAR_PLAIN    = 2'd0;
    localparam logic [1:0] VAR_REPLAY   = 2'd1;
    localparam logic [1:0] VAR_WIDE_RET = 2'd2;

    // Template flag positions
    localparam int T_KEY  = 0;
    localparam int T_SH   = 1;
    localparam int T_WKEY = 2;
    localparam int T_WSH  = 3;
    localparam int T_RKEY = 4;
    localparam int T_RSH  = 5;
    localparam int NUM_TMPL = 6;

    // Result bit positions in the output tdata
    localparam int RES_REGULAR = 0;
    localparam int RES_SH      = 1;
    localparam int RES_WITNESS = 2;
    localparam int RES_RETURN  = 3;
    localparam int RES_CREATE  = 4;
    localparam int RES_CALL    = 5;
    localparam int RES_W       = 6;

    // Script opcodes and length bytes
    localparam logic [7:0] OP_0           = 8'h00;
    localparam logic [7:0] PUSH_20        = 8'h14;
    localparam logic [7:0] PUSH_32        = 8'h20;
    localparam logic [7:0] OP_RETURN      = 8'h6A;
    localparam logic [7:0] OP_DUP         = 8'h76;
    localparam logic [7:0] CMP_EQ         = 8'h87;
    localparam logic [7:0] CMP_EQ_VERIFY  = 8'h88;
    localparam logic [7:0] HASH_20        = 8'hA9;
    localparam logic [7:0] SIG_CHECK      = 8'hAC;
    localparam logic [7:0] OP_CREATE      = 8'hC1;
    localparam logic [7:0] OP_CALL        = 8'hC2;
    localparam logic [7:0] MAX_INDEX      = 8'hEA;
    localparam logic [7:0] LEN_KEY        = 8'h19;
    localparam logic [7:0] LEN_SH         = 8'h17;
    localparam logic [7:0] LEN_WKEY       = 8'h16;
    localparam logic [7:0] LEN_WSH        = 8'h22;
    localparam logic [7:0] LEN_RKEY       = 8'h3F;
    localparam logic [7:0] LEN_RSH        = 8'h3D;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;

    // Bytes needed before a template can count as matched
    localparam logic [7:0] NEED_KEY  = 8'd26;
    localparam logic [7:0] NEED_SH   = 8'd24;
    localparam logic [7:0] NEED_WIT  = 8'd3;
    localparam logic [7:0] NEED_RKEY = 8'd64;
    localparam logic [7:0] NEED_RSH  = 8'd62;

    // Head bytes, fourth entry unused where the head is three long
    localparam logic [7:0] HEAD_KEY  [4] = '{LEN_KEY,  OP_DUP,  HASH_20, PUSH_20};
    localparam logic [7:0] HEAD_SH   [4] = '{LEN_SH,   HASH_20, PUSH_20, OP_0};
    localparam logic [7:0] HEAD_WKEY [4] = '{LEN_WKEY, OP_0,    PUSH_20, OP_0};
    localparam logic [7:0] HEAD_WSH  [4] = '{LEN_WSH,  OP_0,    PUSH_32, OP_0};
    localparam logic [7:0] HEAD_RKEY [4] = '{LEN_RKEY, OP_DUP,  HASH_20, PUSH_20};
    localparam logic [7:0] HEAD_RSH  [4] = '{LEN_RSH,  HASH_20, PUSH_20, OP_0};

    // Replay-protection tail shared by both replay forms, after its push byte
    localparam int RTAIL_LEN = 37;
    localparam logic [7:0] REPLAY_TAIL [RTAIL_LEN] = '{
        8'h9E, 8'hC9, 8'h84, 8'h5A, 8'hCB, 8'h02, 8'hFA, 8'hB2, 8'h4E, 8'h1C, 8'h03,
        8'h68, 8'hB3, 8'hB5, 8'h17, 8'hC1, 8'hA4, 8'h48, 8'h8F, 8'hBA, 8'h97, 8'hF0,
        8'hE3, 8'h45, 8'h9A, 8'hC0, 8'h53, 8'hEA, 8'h01, 8'h00, 8'h00, 8'h00,
        8'h03, 8'hC0, 8'h1F, 8'h02, 8'hB4
    };
    localparam logic [7:0] RKEY_TAIL_AT = 8'd27;
    localparam logic [7:0] RSH_TAIL_AT  = 8'd25;

    // One bit per template: byte b at position pos agrees, or is not checked
    function automatic logic [NUM_TMPL-1:0] tmpl_agree(input logic [7:0] pos,
                                                       input logic [7:0] b);
        logic [NUM_TMPL-1:0] ok;
        logic [7:0]          off_rkey;
        logic [7:0]          off_rsh;
        ok       = '1;
        off_rkey = pos - RKEY_TAIL_AT;
        off_rsh  = pos - RSH_TAIL_AT;
        if (pos < 8'd4)
        begin
            ok[T_KEY]  = (b == HEAD_KEY[pos[1:0]]);
            ok[T_RKEY] = (b == HEAD_RKEY[pos[1:0]]);
        end
        if (pos < 8'd3)
        begin
            ok[T_SH]   = (b == HEAD_SH[pos[1:0]]);
            ok[T_WKEY] = (b == HEAD_WKEY[pos[1:0]]);
            ok[T_WSH]  = (b == HEAD_WSH[pos[1:0]]);
            ok[T_RSH]  = (b == HEAD_RSH[pos[1:0]]);
        end
        if (pos == 8'd23)
        begin
            ok[T_SH]  = (b == CMP_EQ);
            ok[T_RSH] = (b == CMP_EQ);
        end
        if (pos == 8'd24)
        begin
            ok[T_KEY]  = (b == CMP_EQ_VERIFY);
            ok[T_RKEY] = (b == CMP_EQ_VERIFY);
            ok[T_RSH]  = (b == PUSH_32);
        end
        if (pos == 8'd25)
        begin
            ok[T_KEY]  = (b == SIG_CHECK);
            ok[T_RKEY] = (b == SIG_CHECK);
        end
        if (pos == 8'd26)
            ok[T_RKEY] = (b == PUSH_32);
        if (pos >= RKEY_TAIL_AT && pos < NEED_RKEY)
            ok[T_RKEY] = (b == REPLAY_TAIL[off_rkey[5:0]]);
        if (pos >= RSH_TAIL_AT && pos < NEED_RSH)
            ok[T_RSH] = (b == REPLAY_TAIL[off_rsh[5:0]]);
        return ok;
    endfunction

endpackage

FILE: sv/output_script_template_classifier.sv
// Output script template classifier: top level.
// Depends on ostc_pkg (template tables, opcodes, result layout).
//
//  channel   | signals                              | contents
//  ----------+--------------------------------------+--------------------------------
//  s_axis    | s_axis_tvalid/tready/tdata/tlast     | one script byte; tlast = last_byte
//  m_axis    | m_axis_tvalid/tready/tdata           | one class item per script
//  cfg       | cfg_we, cfg_index, cfg_data          | chain_variant, witness_enable
//
// One script byte is taken every cycle unless a last byte is held by the stall
// below. A byte is registered in the input stage, then updates the template
// flags; on the last byte the classes are formed in that same pass and land in
// the output register, from which the result is offered on m_axis.
// Stalls: only a last byte waiting on a full, unaccepted output register holds
// the input stage; other bytes never wait on the output side.
// Reset clears the script state (flags all set) and both registers.
module output_script_template_classifier
    import ostc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input items
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] script_byte
    input  logic       s_axis_tlast,   // last_byte
    // result items
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] is_regular, [1] is_script_hash,
                                       // [2] is_native_witness, [3] is_op_return,
                                       // [4] is_op_create, [5] is_op_call, [7:6] zero
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [1:0] cfg_data
);

    // config
    logic [1:0] variant_reg;
    logic       witness_reg;

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // per-script state
    logic [7:0]          count_reg,  count_next;
    logic [7:0]          first_reg,  first_next;
    logic [7:0]          second_reg, second_next;
    logic [7:0]          third_reg,  third_next;
    logic [7:0]          idx_reg,    idx_next;
    logic                seen_reg,   seen_next;
    logic [NUM_TMPL-1:0] flags_reg,  flags_next;

    // output register
    logic             m_valid_reg;
    logic [RES_W-1:0] m_res_reg;

    logic             out_free;
    logic             s1_go;
    logic             in_acc;
    logic             live;
    logic [7:0]       idx_pos;
    logic [NUM_TMPL-1:0] agree;
    logic [NUM_TMPL-1:0] full;
    logic             wit, reg_m, sh_m, ret_m, cand;
    logic [RES_W-1:0] res;

    // a non-last byte never needs the output register
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_go         = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(8-RES_W){1'b0}}, m_res_reg};

    // Byte update: position stops at 255, from 255 on nothing is checked
    always_comb
    begin
        live        = (count_reg != COUNT_MAX);
        agree       = tmpl_agree(count_reg, s1_byte_reg);
        flags_next  = live ? (flags_reg & agree) : flags_reg;
        first_next  = (live && count_reg == 8'd0) ? s1_byte_reg : first_reg;
        second_next = (live && count_reg == 8'd1) ? s1_byte_reg : second_reg;
        third_next  = (live && count_reg == 8'd2) ? s1_byte_reg : third_reg;
        // at position 0 the index is the byte itself
        idx_pos     = first_next;
        idx_next    = idx_reg;
        seen_next   = seen_reg;
        if (live && count_reg == idx_pos)
        begin
            idx_next  = s1_byte_reg;
            seen_next = 1'b1;
        end
        count_next  = live ? (count_reg + 8'd1) : count_reg;

        // a template counts only once all its checked bytes arrived
        full[T_KEY]  = flags_next[T_KEY]  && (count_next >= NEED_KEY);
        full[T_SH]   = flags_next[T_SH]   && (count_next >= NEED_SH);
        full[T_WKEY] = flags_next[T_WKEY] && (count_next >= NEED_WIT);
        full[T_WSH]  = flags_next[T_WSH]  && (count_next >= NEED_WIT);
        full[T_RKEY] = flags_next[T_RKEY] && (count_next >= NEED_RKEY);
        full[T_RSH]  = flags_next[T_RSH]  && (count_next >= NEED_RSH);

        wit   = witness_reg && (full[T_WKEY] || full[T_WSH]);
        reg_m = wit || full[T_KEY] || ((variant_reg == VAR_REPLAY) && full[T_RKEY]);
        sh_m  = full[T_SH] || ((variant_reg == VAR_REPLAY) && full[T_RSH]);
        ret_m = ((count_next >= 8'd2) && (second_next == OP_RETURN))
             || ((variant_reg == VAR_WIDE_RET) && (count_next >= 8'd3)
                 && (second_next == OP_0) && (third_next == OP_RETURN));
        cand  = !reg_m && !sh_m && !ret_m && (first_next <= MAX_INDEX)
             && (first_next < count_next) && seen_next;

        res              = '0;
        res[RES_REGULAR] = reg_m;
        res[RES_SH]      = sh_m;
        res[RES_WITNESS] = wit;
        res[RES_RETURN]  = ret_m;
        res[RES_CREATE]  = cand && (idx_next == OP_CREATE);
        res[RES_CALL]    = cand && (idx_next == OP_CALL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg  <= VAR_PLAIN;
            witness_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_byte_reg  <= '0;
            s1_last_reg  <= 1'b0;
            count_reg    <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
            third_reg    <= '0;
            idx_reg      <= '0;
            seen_reg     <= 1'b0;
            flags_reg    <= '1;
            m_valid_reg  <= 1'b0;
            m_res_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CHAIN_VARIANT:  variant_reg <= cfg_data;
                    CFG_WITNESS_ENABLE: witness_reg <= cfg_data[0];
                    default:            variant_reg <= variant_reg;
                endcase
            end

            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
                s1_byte_reg  <= s_axis_tdata;
                s1_last_reg  <= s_axis_tlast;
            end
            else if (s1_go)
                s1_valid_reg <= 1'b0;

            if (s1_go)
            begin
                if (s1_last_reg)
                begin
                    // script done: start clean for the next one
                    count_reg  <= '0;
                    first_reg  <= '0;
                    second_reg <= '0;
                    third_reg  <= '0;
                    idx_reg    <= '0;
                    seen_reg   <= 1'b0;
                    flags_reg  <= '1;
                end
                else
                begin
                    count_reg  <= count_next;
                    first_reg  <= first_next;
                    second_reg <= second_next;
                    third_reg  <= third_next;
                    idx_reg    <= idx_next;
                    seen_reg   <= seen_next;
                    flags_reg  <= flags_next;
                end
            end

            if (s1_go && s1_last_reg)
            begin
                m_valid_reg <= 1'b1;
                m_res_reg   <= res;
            end
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: sv/ostc_checker.sv
// Port-level checker for the classifier, attached by bind below.
// Depends on ostc_pkg and output_script_template_classifier_assert.svh.
`include "output_script_template_classifier_assert.svh"

module ostc_checker
    import ostc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic stalled;
    logic contract;
    logic both_contract;
    logic other_class;
    logic wit_item;
    logic contract_item;

    assign stalled       = m_axis_tvalid && !m_axis_tready;
    assign contract      = m_axis_tdata[RES_CREATE] || m_axis_tdata[RES_CALL];
    assign both_contract = m_axis_tdata[RES_CREATE] && m_axis_tdata[RES_CALL];
    assign other_class   = m_axis_tdata[RES_REGULAR] || m_axis_tdata[RES_SH]
                        || m_axis_tdata[RES_RETURN];
    assign wit_item      = m_axis_tvalid && m_axis_tdata[RES_WITNESS];
    assign contract_item = m_axis_tvalid && contract;

    // stalled item holds
    `OSTC_ASSERT_NEXT(a_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata), "item not held")

    // pad bits are zero
    `OSTC_ASSERT_HOLDS(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:6] == 2'b00, "pad bits set")

    // witness is a kind of regular
    `OSTC_ASSERT_HOLDS(a_wit_regular, wit_item, m_axis_tdata[RES_REGULAR], "witness alone")

    // contract classes only when nothing else matched, never both
    `OSTC_ASSERT_HOLDS(a_contract_excl, contract_item, !other_class && !both_contract, "overlap")

endmodule

bind output_script_template_classifier ostc_checker u_ostc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
